>>> hdl/islip_pkg.sv
// Shared constants, opcodes and the command word type of the iSLIP scheduler.
// No dependencies; compile this file first.
package islip_pkg;

   // Default sizes, handed to the top level parameters
   localparam int PORTS_DEF       = 4;
   localparam int QUEUE_DEPTH_DEF = 16;

   // Fixed field widths of the request and response words
   localparam int OP_W        = 1;
   localparam int PORT_W      = 2;
   localparam int MATCH_IN_W  = 4;
   localparam int MATCH_OUT_W = 8;
   localparam int BACKLOG_W   = 9;

   // Opcodes of the request word
   localparam logic [OP_W-1:0] OP_ARRIVAL = 1'b0;
   localparam logic [OP_W-1:0] OP_TICK    = 1'b1;

   // Command handed from the input stage to the state logic
   typedef struct packed {
      logic              fire;
      logic              tick;
      logic [PORT_W-1:0] src_port;
      logic [PORT_W-1:0] dst_port;
   } islip_cmd_type;

endpackage

>>> hdl/islip_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on islip_pkg for the field widths.
interface islip_req_if import islip_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [PORT_W-1:0] src_port;
   logic [PORT_W-1:0] dst_port;

   modport source (output valid, output op, output src_port, output dst_port, input ready);
   modport sink   (input valid, input op, input src_port, input dst_port, output ready);
endinterface

interface islip_rsp_if import islip_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [MATCH_IN_W-1:0]  matched_inputs;
   logic [MATCH_OUT_W-1:0] matched_outputs;
   logic [BACKLOG_W-1:0]   backlog;
   logic                   drop_seen;

   modport source (output valid, output matched_inputs, output matched_outputs,
                   output backlog, output drop_seen, input ready);
   modport sink   (input valid, input matched_inputs, input matched_outputs,
                   input backlog, input drop_seen, output ready);
endinterface

>>> hdl/islip_voq_scheduler.sv
// Top level of the iSLIP virtual output queue scheduler.
// Depends on islip_pkg, islip_if, islip_match and islip_voq_bank.
//
// The scheduler takes one request word per clock. An accepted word is held
// in an input register; while it is held the grant and accept arbiters
// run over the queue occupancy in a single combinational pass. The queue
// counters and round-robin pointers update at the end of the cycle in
// which the word leaves the input register, and a tick then loads
// its match into the response register, which presents the tick's
// response to the sink. Arrivals produce no
// response. Throughput is one word per cycle; the input stage stalls only
// when a tick is waiting behind a response that the sink has not yet taken.
// The longest path is the grant arbiter feeding the accept arbiter and then
// the counter and pointer update, which grows with PORTS.
module islip_voq_scheduler import islip_pkg::*; #(
   parameter  int PORTS       = PORTS_DEF,
   parameter  int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   localparam int NQ          = PORTS * PORTS,
   localparam int PTR_W       = $clog2(PORTS),
   localparam int BL_W        = $clog2(NQ * QUEUE_DEPTH + 1),
   localparam int SHOWN       = (PORTS < MATCH_IN_W) ? PORTS : MATCH_IN_W,
   localparam int EXT_W       = BL_W + BACKLOG_W
) (
   input  logic               clock,
   input  logic               reset,
   islip_req_if.sink          req_ch,
   islip_rsp_if.source        rsp_ch
);

   // Input stage
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [OP_W-1:0]   s1_op_ff;
   logic [PORT_W-1:0] s1_src_ff;
   logic [PORT_W-1:0] s1_dst_ff;
   logic              advance;
   logic              req_take;
   islip_cmd_type     cmd;

   // Response stage
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [MATCH_IN_W-1:0]  rsp_min_ff;
   logic [MATCH_OUT_W-1:0] rsp_mout_ff;
   logic [BACKLOG_W-1:0]   rsp_backlog_ff;
   logic                   rsp_drop_ff;

   // Between the parts
   logic [NQ-1:0]          nonempty;
   logic [NQ-1:0]          acc_mat;
   logic [PTR_W-1:0]       acc_idx [PORTS];
   logic [PORTS-1:0]       acc_any;
   logic [BL_W-1:0]        backlog_next;
   logic                   drop_flag;
   logic [MATCH_IN_W-1:0]  match_in;
   logic [MATCH_OUT_W-1:0] match_out;
   logic [PTR_W+1:0]       idx_ext [SHOWN];
   logic [EXT_W-1:0]       backlog_ext;

   // Advance the held word unless a tick must wait for the response register
   assign advance  = s1_valid_ff &&
                     (s1_op_ff == OP_ARRIVAL || !rsp_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !s1_valid_ff || advance;

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Capture the word payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff  <= req_ch.op;
         s1_src_ff <= req_ch.src_port;
         s1_dst_ff <= req_ch.dst_port;
      end
   end

   assign cmd.fire     = advance;
   assign cmd.tick     = (s1_op_ff == OP_TICK);
   assign cmd.src_port = s1_src_ff;
   assign cmd.dst_port = s1_dst_ff;

   islip_match #(.PORTS(PORTS)) u_match (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .nonempty (nonempty),
      .acc_mat  (acc_mat),
      .acc_idx  (acc_idx),
      .acc_any  (acc_any)
   );

   islip_voq_bank #(.PORTS(PORTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_bank (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .acc_mat      (acc_mat),
      .nonempty     (nonempty),
      .backlog_next (backlog_next),
      .drop_flag    (drop_flag)
   );

   // Pack the match of the low inputs into the response fields
   always_comb begin
      match_in  = '0;
      match_out = '0;
      for (int i = 0; i < SHOWN; i++) begin
         idx_ext[i]       = (PTR_W+2)'(acc_idx[i]);
         match_in[i]      = acc_any[i];
         match_out[2*i +: 2] = acc_any[i] ? idx_ext[i][1:0] : 2'b00;
      end
   end

   assign backlog_ext = EXT_W'(backlog_next);

   // Load the response on a tick, drop it once taken
   always_comb begin
      if (advance && cmd.tick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && cmd.tick) begin
         rsp_min_ff     <= match_in;
         rsp_mout_ff    <= match_out;
         rsp_backlog_ff <= backlog_ext[BACKLOG_W-1:0];
         rsp_drop_ff    <= drop_flag;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.matched_inputs  = rsp_min_ff;
   assign rsp_ch.matched_outputs = rsp_mout_ff;
   assign rsp_ch.backlog         = rsp_backlog_ff;
   assign rsp_ch.drop_seen       = rsp_drop_ff;

   // A new response only follows a tick leaving the input stage
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && cmd.tick))
      else $error("response raised without a tick");

   // A pair is accepted only for a queue that holds packets
   a_acc_nonempty: assert property (@(posedge clock) disable iff (reset)
      ((acc_mat & ~nonempty) == '0))
      else $error("accepted an empty queue");

   // A stalled word keeps its place and payload
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_op_ff)
                                     && $stable(s1_src_ff) && $stable(s1_dst_ff)))
      else $error("input stage lost a stalled word");

endmodule

>>> hdl/islip_rr_arb.sv
// Round-robin arbiter: picks the first request at or after a pointer.
// Depends on islip_pkg for the default width.
module islip_rr_arb import islip_pkg::*; #(
   parameter  int N = PORTS_DEF,
   localparam int W = $clog2(N)
) (
   input  logic [N-1:0] req,
   input  logic [W-1:0] ptr,
   output logic [N-1:0] gnt,
   output logic [W-1:0] idx
);

   logic [N-1:0] upper_mask;
   logic [N-1:0] masked;
   logic [N-1:0] pick;

   // Prefer requests at or above the pointer, else wrap to the lowest one
   always_comb begin
      for (int k = 0; k < N; k++) begin
         upper_mask[k] = (k >= int'(ptr));
      end
      masked = req & upper_mask;
      pick   = (|masked) ? masked : req;
      gnt    = pick & (~pick + 1'b1);
   end

   // Encode the one-hot grant
   always_comb begin
      idx = '0;
      for (int k = 0; k < N; k++) begin
         if (gnt[k]) begin
            idx = idx | W'(k);
         end
      end
   end

endmodule

>>> hdl/islip_match.sv
// Single-iteration iSLIP matcher: grant and accept arbiters plus their pointers.
// Depends on islip_pkg and islip_rr_arb.
module islip_match import islip_pkg::*; #(
   parameter  int PORTS = PORTS_DEF,
   localparam int PTR_W = $clog2(PORTS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  islip_cmd_type            cmd,
   input  logic [PORTS*PORTS-1:0]   nonempty,
   output logic [PORTS*PORTS-1:0]   acc_mat,
   output logic [PTR_W-1:0]         acc_idx [PORTS],
   output logic [PORTS-1:0]         acc_any
);

   logic [PTR_W-1:0] gpos_ff [PORTS];
   logic [PTR_W-1:0] gpos_in [PORTS];
   logic [PTR_W-1:0] apos_ff [PORTS];
   logic [PTR_W-1:0] apos_in [PORTS];

   logic [PORTS-1:0] grant_req [PORTS];
   logic [PORTS-1:0] grant_oh  [PORTS];
   logic [PTR_W-1:0] grant_idx [PORTS];
   logic [PORTS-1:0] accept_req [PORTS];
   logic [PORTS-1:0] accept_oh  [PORTS];
   logic [PORTS-1:0] out_taken;
   logic             tick_go;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (int'(p) == PORTS - 1) ? '0 : p + 1'b1;
   endfunction

   // Route queue occupancy to the output arbiters and grants to the input arbiters
   always_comb begin
      for (int i = 0; i < PORTS; i++) begin
         for (int j = 0; j < PORTS; j++) begin
            grant_req[j][i]  = nonempty[i*PORTS + j];
            accept_req[i][j] = grant_oh[j][i];
         end
      end
   end

   // Grant stage: one arbiter per output
   for (genvar j = 0; j < PORTS; j++) begin : g_grant
      islip_rr_arb #(.N(PORTS)) u_grant (
         .req (grant_req[j]),
         .ptr (gpos_ff[j]),
         .gnt (grant_oh[j]),
         .idx (grant_idx[j])
      );
   end

   // Accept stage: one arbiter per input
   for (genvar i = 0; i < PORTS; i++) begin : g_accept
      islip_rr_arb #(.N(PORTS)) u_accept (
         .req (accept_req[i]),
         .ptr (apos_ff[i]),
         .gnt (accept_oh[i]),
         .idx (acc_idx[i])
      );
   end

   // Flatten the accepted pairs and mark outputs that were taken
   always_comb begin
      out_taken = '0;
      for (int i = 0; i < PORTS; i++) begin
         acc_any[i] = |accept_oh[i];
         for (int j = 0; j < PORTS; j++) begin
            acc_mat[i*PORTS + j] = accept_oh[i][j];
            out_taken[j]         = out_taken[j] | accept_oh[i][j];
         end
      end
   end

   // Advance pointers one past the partner, for accepted pairs only
   assign tick_go = cmd.fire && cmd.tick;

   always_comb begin
      for (int p = 0; p < PORTS; p++) begin
         gpos_in[p] = gpos_ff[p];
         apos_in[p] = apos_ff[p];
         if (tick_go && out_taken[p]) begin
            gpos_in[p] = ptr_next(grant_idx[p]);
         end
         if (tick_go && acc_any[p]) begin
            apos_in[p] = ptr_next(acc_idx[p]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PORTS; p++) begin
            gpos_ff[p] <= '0;
            apos_ff[p] <= '0;
         end
      end else begin
         for (int p = 0; p < PORTS; p++) begin
            gpos_ff[p] <= gpos_in[p];
            apos_ff[p] <= apos_in[p];
         end
      end
   end

endmodule

>>> hdl/islip_voq_bank.sv
// Virtual output queue occupancy counters, total backlog and sticky drop flag.
// Depends on islip_pkg for the command word type.
module islip_voq_bank import islip_pkg::*; #(
   parameter  int PORTS       = PORTS_DEF,
   parameter  int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   localparam int NQ          = PORTS * PORTS,
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1),
   localparam int BL_W        = $clog2(NQ * QUEUE_DEPTH + 1),
   localparam int MCNT_W      = $clog2(PORTS + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  islip_cmd_type   cmd,
   input  logic [NQ-1:0]   acc_mat,
   output logic [NQ-1:0]   nonempty,
   output logic [BL_W-1:0] backlog_next,
   output logic            drop_flag
);

   logic [CNT_W-1:0]  count_ff [NQ];
   logic [CNT_W-1:0]  count_in [NQ];
   logic [BL_W-1:0]   backlog_ff;
   logic [BL_W-1:0]   backlog_in;
   logic              drop_ff;
   logic              drop_in;
   logic              arrive;
   logic              tick_go;
   logic              add_ok;
   logic              full_hit;
   logic [MCNT_W-1:0] num_match;

   assign arrive  = cmd.fire && !cmd.tick;
   assign tick_go = cmd.fire && cmd.tick;

   // Bump the addressed queue on arrival, drain accepted queues on a tick
   always_comb begin
      add_ok    = 1'b0;
      full_hit  = 1'b0;
      num_match = '0;
      for (int i = 0; i < PORTS; i++) begin
         for (int j = 0; j < PORTS; j++) begin
            count_in[i*PORTS + j] = count_ff[i*PORTS + j];
            if (arrive && int'(cmd.src_port) == i && int'(cmd.dst_port) == j) begin
               if (count_ff[i*PORTS + j] == CNT_W'(QUEUE_DEPTH)) begin
                  full_hit = 1'b1;
               end else begin
                  count_in[i*PORTS + j] = count_ff[i*PORTS + j] + 1'b1;
                  add_ok                = 1'b1;
               end
            end
            if (tick_go && acc_mat[i*PORTS + j]) begin
               count_in[i*PORTS + j] = count_ff[i*PORTS + j] - 1'b1;
               num_match             = num_match + 1'b1;
            end
         end
      end
   end

   // Track the total backlog and the sticky drop flag
   always_comb begin
      backlog_in = backlog_ff + BL_W'(add_ok) - BL_W'(num_match);
      if (tick_go) begin
         drop_in = 1'b0;
      end else if (full_hit) begin
         drop_in = 1'b1;
      end else begin
         drop_in = drop_ff;
      end
   end

   always_comb begin
      for (int q = 0; q < NQ; q++) begin
         nonempty[q] = (count_ff[q] != '0);
      end
   end

   assign backlog_next = backlog_in;
   assign drop_flag    = drop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < NQ; q++) begin
            count_ff[q] <= '0;
         end
         backlog_ff <= '0;
         drop_ff    <= 1'b0;
      end else begin
         for (int q = 0; q < NQ; q++) begin
            count_ff[q] <= count_in[q];
         end
         backlog_ff <= backlog_in;
         drop_ff    <= drop_in;
      end
   end

endmodule

>>> verif/islip_voq_scheduler_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the iSLIP virtual output queue scheduler.
// Depends on islip_pkg, islip_if and the islip_voq_scheduler top level.
module islip_voq_scheduler_tb;
   import islip_pkg::*;

   localparam int NP          = PORTS_DEF;
   localparam int IDLE_LIMIT  = 4000;
   localparam int SHOW_LIMIT  = 10;
   localparam int RANDOM_WORDS = 800;

   // Idling phases of the two channels
   typedef enum logic [1:0] {
      GAP_NONE,
      GAP_SEND,
      GAP_RECV,
      GAP_BOTH
   } gap_mode_type;

   // One request word plus how the sender paces it
   typedef struct {
      logic [OP_W-1:0]   op;
      logic [PORT_W-1:0] src_port;
      logic [PORT_W-1:0] dst_port;
      gap_mode_type      gap;
      bit                drain_first;
   } slot_word_type;

   // One match report as the response channel carries it
   typedef struct packed {
      logic [MATCH_IN_W-1:0]  matched_inputs;
      logic [MATCH_OUT_W-1:0] matched_outputs;
      logic [BACKLOG_W-1:0]   backlog;
      logic                   drop_seen;
   } match_report_type;

   logic clock;
   logic reset;

   islip_req_if req_ch ();
   islip_rsp_if rsp_ch ();

   islip_voq_scheduler dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   slot_word_type    pending_words[$];
   match_report_type match_expect_q[$];
   gap_mode_type     gap_now;
   int               mismatches;
   int               idle_cycles;

   // Shadow of the scheduler state
   logic [4:0]          voq_fill [NP][NP];
   logic [PORT_W-1:0]   gnt_pos [NP];
   logic [PORT_W-1:0]   acc_pos [NP];
   logic [BACKLOG_W-1:0] backlog_total;
   logic                drop_pending;

   always #5 clock = ~clock;

   // Percent of cycles that one side spends idle in a given phase
   function automatic int gap_pct(gap_mode_type mode, bit send_side);
      case (mode)
         GAP_SEND: return send_side ? 82 : 0;
         GAP_RECV: return send_side ? 0 : 82;
         GAP_BOTH: return 11;
         default:  return 0;
      endcase
   endfunction

   // Count an arrival into its queue, or flag the drop when the queue is full
   function automatic void enqueue_packet(logic [PORT_W-1:0] s, logic [PORT_W-1:0] d);
      if (voq_fill[s][d] >= QUEUE_DEPTH_DEF) begin
         drop_pending = 1'b1;
      end else begin
         voq_fill[s][d] = voq_fill[s][d] + 1'b1;
         backlog_total  = backlog_total + 1'b1;
      end
   endfunction

   // Single iSLIP iteration: grant per output, accept per input, then transfer
   function automatic match_report_type run_islip_slot();
      int               grant_to [NP];
      int               accept_of [NP];
      int               i;
      int               j;
      int               k;
      match_report_type rpt;
      rpt = '0;
      for (j = 0; j < NP; j++) begin
         grant_to[j] = -1;
         for (k = 0; k < NP; k++) begin
            i = (gnt_pos[j] + k) % NP;
            if (grant_to[j] < 0 && voq_fill[i][j] != 0) grant_to[j] = i;
         end
      end
      for (i = 0; i < NP; i++) begin
         accept_of[i] = -1;
         for (k = 0; k < NP; k++) begin
            j = (acc_pos[i] + k) % NP;
            if (accept_of[i] < 0 && grant_to[j] == i) accept_of[i] = j;
         end
      end
      for (i = 0; i < NP; i++) begin
         if (accept_of[i] >= 0) begin
            j = accept_of[i];
            gnt_pos[j] = PORT_W'((i + 1) % NP);
            acc_pos[i] = PORT_W'((j + 1) % NP);
            voq_fill[i][j] = voq_fill[i][j] - 1'b1;
            backlog_total  = backlog_total - 1'b1;
            rpt.matched_inputs[i]          = 1'b1;
            rpt.matched_outputs[2*i +: 2]  = PORT_W'(j);
         end
      end
      rpt.backlog   = backlog_total;
      rpt.drop_seen = drop_pending;
      drop_pending  = 1'b0;
      return rpt;
   endfunction

   function automatic void add_word(logic [OP_W-1:0] op, int s, int d, gap_mode_type gap,
                                    bit drain_first);
      slot_word_type w;
      w.op          = op;
      w.src_port    = PORT_W'(s);
      w.dst_port    = PORT_W'(d);
      w.gap         = gap;
      w.drain_first = drain_first;
      pending_words.insert(pending_words.size(), w);
   endfunction

   function automatic void note_mismatch(string field, int exp_val, int act_val);
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field,
                  exp_val, act_val);
   endfunction

   // Driver: predict each accepted word, then present the next one
   always @(posedge clock) begin
      logic          nxt_valid;
      logic          accepted;
      slot_word_type w;
      nxt_valid = 1'b0;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         accepted = req_ch.valid && req_ch.ready;
         if (accepted) begin
            if (req_ch.op == OP_TICK)
               match_expect_q.insert(match_expect_q.size(), run_islip_slot());
            else enqueue_packet(req_ch.src_port, req_ch.dst_port);
         end
         if (req_ch.valid && !accepted) begin
            nxt_valid = 1'b1;
         end else if (pending_words.size() != 0) begin
            w = pending_words[0];
            gap_now <= w.gap;
            // hold off until every outstanding report has come back
            if (!(w.drain_first && match_expect_q.size() != 0) &&
                $urandom_range(0, 99) >= gap_pct(w.gap, 1'b1)) begin
               void'(pending_words.pop_front());
               req_ch.op       <= w.op;
               req_ch.src_port <= w.src_port;
               req_ch.dst_port <= w.dst_port;
               nxt_valid = 1'b1;
            end
         end
         req_ch.valid <= nxt_valid;
      end
   end

   // Receiver: stall the response channel according to the current phase
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= gap_pct(gap_now, 1'b0));
   end

   // Monitor: check each taken report against the oldest prediction
   always @(posedge clock) begin
      match_report_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (match_expect_q.size() == 0) begin
            note_mismatch("unexpected report, matched_inputs", -1, rsp_ch.matched_inputs);
         end else begin
            want = match_expect_q.pop_front();
            if (rsp_ch.matched_inputs !== want.matched_inputs)
               note_mismatch("matched_inputs", want.matched_inputs, rsp_ch.matched_inputs);
            if (rsp_ch.matched_outputs !== want.matched_outputs)
               note_mismatch("matched_outputs", want.matched_outputs, rsp_ch.matched_outputs);
            if (rsp_ch.backlog !== want.backlog)
               note_mismatch("backlog", want.backlog, rsp_ch.backlog);
            if (rsp_ch.drop_seen !== want.drop_seen)
               note_mismatch("drop_seen", want.drop_seen, rsp_ch.drop_seen);
         end
      end
   end

   // Watchdog: end the run when neither channel moves a word for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("islip_voq_scheduler verification failed");
            $finish;
         end
      end
   end

   initial begin
      int           fill_order[$];
      int           a;
      int           b;
      int           tmp;
      int           seg;
      int           seg_len;
      int           arrival_pct;
      int           word_total;
      gap_mode_type mode;

      clock           = 1'b0;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.op       = OP_ARRIVAL;
      req_ch.src_port = '0;
      req_ch.dst_port = '0;
      rsp_ch.ready    = 1'b0;
      gap_now         = GAP_NONE;
      mismatches      = 0;
      idle_cycles     = 0;
      backlog_total   = '0;
      drop_pending    = 1'b0;
      for (a = 0; a < NP; a++) begin
         gnt_pos[a] = '0;
         acc_pos[a] = '0;
         for (b = 0; b < NP; b++) voq_fill[a][b] = '0;
      end

      // Directed: empty switch, contention at one input, full queue and drop flag
      add_word(OP_TICK, 0, 0, GAP_NONE, 1'b0);
      add_word(OP_ARRIVAL, 0, 3, GAP_NONE, 1'b0);
      add_word(OP_ARRIVAL, 3, 0, GAP_NONE, 1'b0);
      add_word(OP_ARRIVAL, 0, 0, GAP_NONE, 1'b0);
      add_word(OP_TICK, 3, 3, GAP_NONE, 1'b0);
      for (a = 0; a <= QUEUE_DEPTH_DEF; a++) add_word(OP_ARRIVAL, 3, 3, GAP_NONE, 1'b0);
      add_word(OP_TICK, 0, 0, GAP_NONE, 1'b0);
      add_word(OP_TICK, 0, 0, GAP_NONE, 1'b0);

      // Fill every queue past its depth in shuffled order, once every outstanding report is back
      for (a = 0; a < NP * NP; a++)
         for (b = 0; b <= QUEUE_DEPTH_DEF; b++) fill_order.insert(fill_order.size(), a);
      for (a = fill_order.size() - 1; a > 0; a--) begin
         b = $urandom_range(0, a);
         tmp = fill_order[a];
         fill_order[a] = fill_order[b];
         fill_order[b] = tmp;
      end
      for (a = 0; a < fill_order.size(); a++)
         add_word(OP_ARRIVAL, fill_order[a] / NP, fill_order[a] % NP, GAP_BOTH, a == 0);

      // Random segments: load mix and idling phase change per segment
      word_total = 0;
      seg = 0;
      while (word_total < RANDOM_WORDS) begin
         seg_len = $urandom_range(30, 120);
         mode = gap_mode_type'(seg % 4);
         case ($urandom_range(0, 3))
            0:       arrival_pct = 20;
            1:       arrival_pct = 50;
            2:       arrival_pct = 75;
            default: arrival_pct = 90;
         endcase
         for (a = 0; a < seg_len; a++)
            add_word(($urandom_range(0, 99) < arrival_pct) ? OP_ARRIVAL : OP_TICK,
                     $urandom_range(0, NP - 1), $urandom_range(0, NP - 1), mode,
                     a == 0 && seg % 3 == 0);
         word_total += seg_len;
         seg++;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Wait for the stimulus to go out and every report to come back
      while (pending_words.size() != 0 || req_ch.valid) @(posedge clock);
      while (match_expect_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0 && match_expect_q.size() == 0) begin
         $display("islip_voq_scheduler verification clean");
      end else begin
         $display("islip_voq_scheduler verification failed");
      end
      $finish;
   end

endmodule
